>>> rtl/ute_pkg.sv
// Shared constants for the unsorted table engine: table depth, derived widths,
// operation codes and result status codes. No dependencies.
`default_nettype none

package ute_pkg;

	// Table geometry
	localparam int DEPTH  = 64;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int OP_W   = 2;
	localparam int STAT_W = 2;

	// Operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;
	localparam logic [OP_W-1:0] OP_LIST   = 2'd3;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_MISSING = 2'd2;
	localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd3;

endpackage

`default_nettype wire

>>> rtl/unsorted_table_engine.sv
// Unsorted table engine: a table of signed words in one synchronous memory plus a fill count.
// Depends on ute_pkg for depth, widths and codes.
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------------
//   in      | in_valid / in_ready | opcode, key, new_value
//   out     | out_valid/out_ready | status, value, entry_count, last
//
// Insert goes straight to its result; modify and delete search the stored entries
// in order (one memory read per cycle); a delete hit then moves each later entry
// down one slot; list streams one entry per cycle when the output is taken every
// cycle. The single memory read port sets this pace.
// Reset clears the fill count and control only; the memory is not cleared.
// A stalled output holds the list walk and the result in place; a new item is taken once the final
// result of the previous one sits in the output register.
`default_nettype none

module unsorted_table_engine
	import ute_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic        [OP_W-1:0]   opcode,
	input  wire logic signed [DATA_W-1:0] key,
	input  wire logic signed [DATA_W-1:0] new_value,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic             [STAT_W-1:0] status,
	output logic signed      [DATA_W-1:0] value,
	output logic             [CNT_W-1:0]  entry_count,
	output logic                          last
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SRCH  = 3'd1;
	localparam logic [2:0] S_SHIFT = 3'd2;
	localparam logic [2:0] S_LIST  = 3'd3;
	localparam logic [2:0] S_RESP  = 3'd4;

	logic [2:0]               state_q;
	logic [CNT_W-1:0]         fill_q;
	logic [CNT_W-1:0]         idx_q;
	logic [CNT_W-1:0]         pidx_s1;
	logic                     pend_s1;
	logic [OP_W-1:0]          op_q;
	logic [DATA_W-1:0]        key_q;
	logic [DATA_W-1:0]        nv_q;
	logic [STAT_W-1:0]        rsp_status_q;

	logic                     out_valid_q;
	logic [STAT_W-1:0]        out_status_q;
	logic [DATA_W-1:0]        out_value_q;
	logic [CNT_W-1:0]         out_count_q;
	logic                     out_last_q;

	logic [DATA_W-1:0]        mem [DEPTH];
	logic [DATA_W-1:0]        rd_data_s1;

	logic                     in_fire;
	logic                     slot_free;
	logic                     full;
	logic [CNT_W-1:0]         fill_last;
	logic [CNT_W-1:0]         sh_wa;
	logic                     hit;
	logic                     at_end;
	logic                     srch_issue;
	logic                     shift_issue;
	logic                     shift_done;
	logic                     list_issue;
	logic                     list_emit;
	logic                     resp_emit;
	logic                     ins_we;
	logic                     mod_we;
	logic                     sh_we;
	logic                     re;
	logic                     we;
	logic [ADDR_W-1:0]        wa;
	logic [DATA_W-1:0]        wd;

	// Handshake and walk control
	assign in_ready    = (state_q == S_IDLE);
	assign in_fire     = in_valid && in_ready;
	assign slot_free   = !out_valid_q || out_ready;
	assign full        = (fill_q >= CNT_W'(DEPTH));
	assign fill_last   = fill_q - CNT_W'(1);
	assign sh_wa       = pidx_s1 - CNT_W'(1);
	assign hit         = pend_s1 && (rd_data_s1 == key_q);
	assign at_end      = (pidx_s1 == fill_last);
	assign srch_issue  = (state_q == S_SRCH) && !(pend_s1 && (hit || at_end));
	assign shift_issue = (state_q == S_SHIFT) && (idx_q < fill_q);
	assign shift_done  = (state_q == S_SHIFT) && !shift_issue && !pend_s1;
	assign list_emit   = (state_q == S_LIST) && pend_s1 && slot_free;
	assign list_issue  = (state_q == S_LIST) && (idx_q < fill_q) && (!pend_s1 || slot_free);
	assign resp_emit   = (state_q == S_RESP) && slot_free;
	assign ins_we      = in_fire && (opcode == OP_INSERT) && !full;
	assign mod_we      = (state_q == S_SRCH) && hit && (op_q == OP_MODIFY);
	assign sh_we       = (state_q == S_SHIFT) && pend_s1;
	assign re          = srch_issue || shift_issue || list_issue;
	assign we          = ins_we || mod_we || sh_we;

	// Select the single write port source
	always_comb begin
		priority if (ins_we) begin
			wa = fill_q[ADDR_W-1:0];
			wd = new_value;
		end else if (mod_we) begin
			wa = pidx_s1[ADDR_W-1:0];
			wd = nv_q;
		end else begin
			wa = sh_wa[ADDR_W-1:0];
			wd = rd_data_s1;
		end
	end

	// Table memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_data_s1 <= mem[idx_q[ADDR_W-1:0]];
		end
	end

	// Sequencer: search, shift down, list, respond
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_q       <= '0;
			idx_q        <= '0;
			pidx_s1      <= '0;
			pend_s1      <= 1'b0;
			rsp_status_q <= STAT_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					idx_q   <= '0;
					pend_s1 <= 1'b0;
					if (in_fire) begin
						unique case (opcode)
							OP_INSERT: begin
								rsp_status_q <= full ? STAT_FULL : STAT_OK;
								if (!full) begin
									fill_q <= fill_q + CNT_W'(1);
								end
								state_q <= S_RESP;
							end
							OP_DELETE, OP_MODIFY: begin
								if (fill_q == '0) begin
									rsp_status_q <= STAT_MISSING;
									state_q      <= S_RESP;
								end else begin
									state_q <= S_SRCH;
								end
							end
							OP_LIST: begin
								if (fill_q == '0) begin
									rsp_status_q <= STAT_EMPTY;
									state_q      <= S_RESP;
								end else begin
									state_q <= S_LIST;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_SRCH: begin
					if (srch_issue) begin
						pend_s1 <= 1'b1;
						pidx_s1 <= idx_q;
						idx_q   <= idx_q + CNT_W'(1);
					end else begin
						pend_s1 <= 1'b0;
						if (hit && (op_q == OP_DELETE)) begin
							idx_q   <= pidx_s1 + CNT_W'(1);
							state_q <= S_SHIFT;
						end else begin
							rsp_status_q <= hit ? STAT_OK : STAT_MISSING;
							state_q      <= S_RESP;
						end
					end
				end
				S_SHIFT: begin
					if (shift_issue) begin
						pend_s1 <= 1'b1;
						pidx_s1 <= idx_q;
						idx_q   <= idx_q + CNT_W'(1);
					end else begin
						pend_s1 <= 1'b0;
					end
					if (shift_done) begin
						fill_q       <= fill_last;
						rsp_status_q <= STAT_OK;
						state_q      <= S_RESP;
					end
				end
				S_LIST: begin
					if (list_issue) begin
						pend_s1 <= 1'b1;
						pidx_s1 <= idx_q;
						idx_q   <= idx_q + CNT_W'(1);
					end else if (list_emit) begin
						pend_s1 <= 1'b0;
					end
					if (list_emit && at_end) begin
						state_q <= S_IDLE;
					end
				end
				S_RESP: begin
					if (resp_emit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Latch the accepted item
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q  <= opcode;
			key_q <= key;
			nv_q  <= new_value;
		end
	end

	// Output register valid: drop on take, set on load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (list_emit || resp_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (list_emit) begin
			out_status_q <= STAT_OK;
			out_value_q  <= rd_data_s1;
			out_count_q  <= fill_q;
			out_last_q   <= at_end;
		end else if (resp_emit) begin
			out_status_q <= rsp_status_q;
			out_value_q  <= '0;
			out_count_q  <= fill_q;
			out_last_q   <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign value       = out_value_q;
	assign entry_count = out_count_q;
	assign last        = out_last_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(DEPTH))
		else $error("fill count above table depth");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ins_we |=> (fill_q == $past(fill_q) + CNT_W'(1)))
		else $error("insert did not grow the fill count");

	a_search_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH || state_q == S_LIST) |-> (fill_q != '0))
		else $error("walk over an empty table");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_s1)
		else $error("pending read left over in idle");

	a_nonlast_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_last_q) |-> (out_status_q == STAT_OK))
		else $error("non-final result with error status");
`endif

endmodule

`default_nettype wire
